>>> rtl/djrt_pkg.sv
// Shared types and constants for the delayed job request table.
// No dependencies; imported by every module under rtl/.
package djrt_pkg;

  localparam int JOB_COUNT   = 16;
  localparam int JOB_IDX_W   = (JOB_COUNT > 1) ? $clog2(JOB_COUNT) : 1;
  localparam int ID_W        = 8;
  localparam int DELAY_W     = 8;
  localparam int PICK_W      = 5;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_START    = 3'd1,
    MODE_CONTINUE = 3'd2,
    MODE_DELAY    = 3'd3,
    MODE_FETCH    = 3'd4,
    MODE_ENABLE   = 3'd5,
    MODE_DISABLE  = 3'd6
  } mode_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [ID_W-1:0]    job_id;
    logic [DELAY_W-1:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [PICK_W-1:0] picked_job;
    logic              wake;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming command
    logic exec;  // apply the captured command and register the result
  } dp_cmd_t;

endpackage

>>> rtl/djrt_ctrl.sv
// Controller for the delayed job request table: accept / execute sequencer.
// Depends on djrt_pkg.
module djrt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output djrt_pkg::dp_cmd_t dp_cmd,
  output logic             out_valid
);
  import djrt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= dp_cmd.exec;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    dp_cmd.load = 1'b0;
    dp_cmd.exec = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          dp_cmd.load = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/djrt_datapath.sv
// Datapath: pending flags, delay counters, enable flag, priority pick.
// Depends on djrt_pkg.
module djrt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  djrt_pkg::dp_cmd_t   dp_cmd,
  input  djrt_pkg::in_item_t  in_item,
  output djrt_pkg::out_item_t out_item
);
  import djrt_pkg::*;

  in_item_t                 cmd_r;
  out_item_t                res_r, res_nxt;
  logic [JOB_COUNT-1:0]     pend_r, pend_nxt;
  logic [DELAY_W-1:0]       cnt_r   [JOB_COUNT];
  logic [DELAY_W-1:0]       cnt_nxt [JOB_COUNT];
  logic                     en_r, en_nxt;

  logic                     id_ok;
  logic [JOB_IDX_W-1:0]     idx;
  logic                     found;
  logic [PICK_W-1:0]        pick;
  logic [DELAY_W-1:0]       dec;

  assign id_ok = ({1'b0, cmd_r.job_id} < (ID_W+1)'(JOB_COUNT));
  assign idx   = cmd_r.job_id[JOB_IDX_W-1:0];

  // lowest pending job
  always_comb begin
    found = 1'b0;
    pick  = PICK_W'(JOB_COUNT);
    for (int k = JOB_COUNT - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        found = 1'b1;
        pick  = PICK_W'(k);
      end
    end
  end

  always_comb begin
    pend_nxt           = pend_r;
    en_nxt             = en_r;
    res_nxt.picked_job = PICK_W'(JOB_COUNT);
    res_nxt.wake       = 1'b0;
    dec                = '0;
    for (int k = 0; k < JOB_COUNT; k++) cnt_nxt[k] = cnt_r[k];

    case (cmd_r.mode)
      MODE_TICK: begin
        if (en_r) begin
          for (int k = 0; k < JOB_COUNT; k++) begin
            if (cnt_r[k] != '0) begin
              cnt_nxt[k] = cnt_r[k] - DELAY_W'(1);
              if (cnt_r[k] == DELAY_W'(1)) begin
                pend_nxt[k]  = 1'b1;
                res_nxt.wake = 1'b1;
              end
            end
          end
        end
      end
      MODE_START: begin
        if (en_r) begin
          if (id_ok) pend_nxt[idx] = 1'b1;
          res_nxt.wake = 1'b1;
        end
      end
      MODE_CONTINUE: begin
        if (en_r && id_ok) pend_nxt[idx] = 1'b1;
      end
      MODE_DELAY: begin
        if (en_r && id_ok && !pend_r[idx]) begin
          dec          = cmd_r.delay_ticks;
          cnt_nxt[idx] = dec;
        end
      end
      MODE_FETCH: begin
        res_nxt.picked_job = pick;
        if (found) pend_nxt[pick[JOB_IDX_W-1:0]] = 1'b0;
      end
      MODE_ENABLE: begin
        pend_nxt = '0;
        for (int k = 0; k < JOB_COUNT; k++) cnt_nxt[k] = '0;
        en_nxt = 1'b1;
      end
      MODE_DISABLE: en_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) cmd_r <= in_item;
    if (dp_cmd.exec) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      en_r   <= 1'b0;
      for (int k = 0; k < JOB_COUNT; k++) cnt_r[k] <= '0;
    end else if (dp_cmd.exec) begin
      pend_r <= pend_nxt;
      en_r   <= en_nxt;
      for (int k = 0; k < JOB_COUNT; k++) cnt_r[k] <= cnt_nxt[k];
    end
  end

  assign out_item = res_r;

endmodule

>>> rtl/delayed_job_request_table.sv
// Delayed job request table: per-job pending flags and delay down-counters
// with a lowest-id fetch. Depends on djrt_pkg, djrt_ctrl, djrt_datapath.
//
// Usage:
//   Command channel: drive in_item and raise start; the command transfers on
//   the rising edge where start is high and busy is low. busy is high for
//   the one execute cycle that follows each transfer.
//   Result channel: every command gives exactly one result. out_valid is high
//   for a single cycle and out_item holds picked_job and wake in that cycle;
//   the receiver takes it at the edge that ends the cycle and cannot stall.
//   Result timing: the command is captured at the transfer, applied in the
//   execute cycle, and out_valid is registered from the execute strobe.
//   A new command cannot transfer while busy, as set by the accept/execute
//   sequence of the controller; the next command may transfer in the cycle
//   that carries the previous result.
//   While enabled, all nonzero counters of the 16 step down in parallel on a
//   tick, and fetch uses a combinational priority pick over the pending flags.
//   Reset (rst_n low, synchronous): table cleared, block disabled, no
//   result pending. Send an enable command before any other command acts.
module delayed_job_request_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  djrt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output djrt_pkg::out_item_t out_item
);
  import djrt_pkg::*;

  dp_cmd_t dp_cmd;

  djrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .dp_cmd    (dp_cmd),
    .out_valid (out_valid)
  );

  djrt_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  // each transfer is followed by its result, registered after the execute cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing after command transfer");

  // a result only follows an execute cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dp_cmd.exec))
    else $error("result without executed command");

  // execute never overlaps a load
  a_exec_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.exec && dp_cmd.load))
    else $error("load during execute");
`endif

endmodule
